>>> design/mmdp_pkg.sv
// Shared types, constants and register codes of the min/max decimating plotter.
// No dependencies; imported by every module of the block.
package mmdp_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int ROW_W          = 17;
  localparam int COL_W          = 16;
  localparam int HEIGHT_W       = 12;
  localparam int SPC_W          = 16;
  localparam int NUM_W          = 33;   // difference of two 32-bit values
  localparam int MAG_W          = 44;   // |num| * height
  localparam int IDX_W          = 3;
  localparam int FIFO_DEPTH_DEF = 4;

  // plot modes
  localparam logic [1:0] MODE_HIST  = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;

  // segment kinds
  localparam logic [1:0] KIND_COLUMN = 2'd0;
  localparam logic [1:0] KIND_LINK   = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;
  localparam logic [1:0] KIND_INVBAR = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_VMIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_VMAX   = 3'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPC    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PZERO  = 3'd5;
  localparam logic [IDX_W-1:0] REG_INVERT = 3'd6;

  // source of a result row
  typedef enum logic [1:0] {
    Y_CONST,
    Y_SCALE,
    Y_LINK,
    Y_COPY
  } ysel_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEL,
    BK_MUL,
    BK_DIV,
    BK_WB
  } back_state_t;

  typedef struct packed {
    logic [1:0]                 plot_mode;
    logic signed [SAMPLE_W-1:0] value_min;
    logic signed [SAMPLE_W-1:0] value_max;
    logic [HEIGHT_W-1:0]        pixel_height;
    logic [SPC_W-1:0]           samples_per_column;
    logic                       plot_zero;
    logic                       invert_bars;
  } cfg_t;

  // one result to be produced by the back end
  typedef struct packed {
    logic [1:0]              kind;
    logic [COL_W-1:0]        x0;
    logic [COL_W-1:0]        x1;
    logic                    last_of_run;
    ysel_t                   y0sel;
    ysel_t                   y1sel;
    logic signed [ROW_W-1:0] y0c;
    logic signed [ROW_W-1:0] y1c;
    logic                    do_link;
    logic signed [NUM_W-1:0] num0;
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num2;
  } job_t;

  function automatic logic signed [NUM_W-1:0] diff33(logic signed [SAMPLE_W-1:0] a,
                                                     logic signed [SAMPLE_W-1:0] b);
    return {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
  endfunction

endpackage

>>> design/mmdp_front.sv
// Front end: folds samples into columns, classifies each closed column and
// emits result jobs. Depends on mmdp_pkg.
module mmdp_front import mmdp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_sample,
  output logic                       job_valid,
  output job_t                       job,
  input  logic                       job_ready
);

  logic [SPC_W-1:0]           group_count;
  logic [COL_W-1:0]           column_index;
  logic signed [SAMPLE_W-1:0] group_low;
  logic signed [SAMPLE_W-1:0] group_high;
  logic                       previous_over;
  logic                       previous_under;
  logic                       pending_link;

  job_t       hold [2];
  logic [1:0] hold_n;

  logic                       accept;
  logic                       line;
  logic [SPC_W-1:0]           limit;
  logic [SPC_W-1:0]           gc_inc;
  logic signed [SAMPLE_W-1:0] nl, nh, clamped;
  logic                       close, over, under;
  job_t                       j [2];
  logic [1:0]                 k, km1;
  job_t                       base;
  logic signed [ROW_W-1:0]    h17;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (hold_n == 2'd0);
  assign job_valid = (hold_n != 2'd0);
  assign job       = hold[0];

  // classification of the incoming sample
  always_comb begin
    line   = (cfg.plot_mode != MODE_HIST) && (cfg.plot_mode != MODE_POINT);
    limit  = (cfg.samples_per_column == '0) ? SPC_W'(1) : cfg.samples_per_column;
    gc_inc = group_count + SPC_W'(1);
    h17    = ROW_W'({1'b0, cfg.pixel_height});
    if (group_count == '0) begin
      nl = sample;
      nh = sample;
    end else begin
      nl = (sample < group_low)  ? sample : group_low;
      nh = (sample > group_high) ? sample : group_high;
    end
    close   = (gc_inc >= limit) || (gc_inc == '0) || last_sample;
    over    = nh > cfg.value_max;
    under   = nl < cfg.value_min;
    clamped = sample;
    if (clamped > cfg.value_max) clamped = cfg.value_max;
    if (clamped < cfg.value_min) clamped = cfg.value_min;

    base      = '0;
    base.x0   = column_index;
    base.x1   = column_index;
    j[0]      = '0;
    j[1]      = '0;
    k         = 2'd0;

    // connector from the previous column
    if (pending_link && line) begin
      j[0]       = '0;
      j[0].kind  = KIND_LINK;
      j[0].x0    = column_index - COL_W'(1);
      j[0].x1    = column_index;
      j[0].y0sel = Y_LINK;
      j[0].y1sel = Y_SCALE;
      j[0].num1  = diff33(clamped, cfg.value_min);
      k          = 2'd1;
    end

    if (close) begin
      if (line) begin
        if (!over && !under) begin
          j[k[0]]         = base;
          j[k[0]].kind    = KIND_COLUMN;
          j[k[0]].y0sel   = previous_over ? Y_CONST : Y_SCALE;
          j[k[0]].y0c     = h17;
          j[k[0]].num0    = diff33(nh, cfg.value_min);
          j[k[0]].y1sel   = previous_under ? Y_CONST : Y_SCALE;
          j[k[0]].num1    = diff33(nl, cfg.value_min);
          j[k[0]].do_link = !last_sample;
          j[k[0]].num2    = diff33(sample, cfg.value_min);
          k = k + 2'd1;
        end
      end else if (cfg.plot_mode == MODE_HIST) begin
        if (cfg.plot_zero || (nh > cfg.value_min)) begin
          j[k[0]] = base;
          if (cfg.invert_bars) begin
            j[k[0]].kind  = KIND_INVBAR;
            j[k[0]].y0sel = over ? Y_CONST : Y_SCALE;
            j[k[0]].num0  = diff33(cfg.value_max, nh);
            j[k[0]].y1c   = h17;
          end else begin
            j[k[0]].kind  = KIND_COLUMN;
            j[k[0]].y0sel = over ? Y_CONST : Y_SCALE;
            j[k[0]].y0c   = h17;
            j[k[0]].num0  = diff33(nh, cfg.value_min);
          end
          k = k + 2'd1;
        end
      end else begin
        if (over) begin
          j[k[0]]       = base;
          j[k[0]].kind  = KIND_POINT;
          j[k[0]].y0sel = Y_SCALE;
          j[k[0]].y1sel = Y_COPY;
          j[k[0]].num0  = diff33(nh, cfg.value_min);
          k = k + 2'd1;
        end
        if (under) begin
          j[k[0]]       = base;
          j[k[0]].kind  = KIND_POINT;
          j[k[0]].y0sel = Y_SCALE;
          j[k[0]].y1sel = Y_COPY;
          j[k[0]].num0  = diff33(nl, cfg.value_min);
          k = k + 2'd1;
        end
      end
    end

    // flag the final result of this sample
    km1 = k - 2'd1;
    if (k != 2'd0) j[km1[0]].last_of_run = 1'b1;
  end

  // column state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count    <= '0;
      column_index   <= '0;
      group_low      <= '0;
      group_high     <= '0;
      previous_over  <= 1'b0;
      previous_under <= 1'b0;
      pending_link   <= 1'b0;
    end else if (accept) begin
      group_low    <= nl;
      group_high   <= nh;
      group_count  <= close ? '0 : gc_inc;
      pending_link <= 1'b0;
      if (close) begin
        column_index <= column_index + COL_W'(1);
        if (line) begin
          if (!over && !under) begin
            previous_over  <= 1'b0;
            previous_under <= 1'b0;
            pending_link   <= !last_sample;
          end else begin
            previous_over  <= over;
            previous_under <= under;
          end
        end
      end
      if (last_sample) begin
        column_index   <= '0;
        previous_over  <= 1'b0;
        previous_under <= 1'b0;
        pending_link   <= 1'b0;
      end
    end
  end

  // job hand-off, one per cycle while job_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_n <= 2'd0;
    end else if (accept) begin
      hold_n <= k;
    end else if (job_valid && job_ready) begin
      hold_n <= hold_n - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold[0] <= j[0];
      hold[1] <= j[1];
    end else if (job_valid && job_ready) begin
      hold[0] <= hold[1];
    end
  end

endmodule

>>> design/mmdp_fifo.sv
// Short job queue between front and back end.
// Depends on mmdp_pkg for the job type.
module mmdp_fifo import mmdp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_pop,
  output job_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

>>> design/mmdp_back.sv
// Back end: scales job numerators to pixel rows with a bit-serial divider
// and drives the result register. Depends on mmdp_pkg.
module mmdp_back import mmdp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    job_valid,
  input  job_t                    job,
  output logic                    job_pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [1:0]              segment_kind,
  output logic [COL_W-1:0]        column_x,
  output logic [COL_W-1:0]        x_end,
  output logic signed [ROW_W-1:0] y_start,
  output logic signed [ROW_W-1:0] y_end,
  output logic                    last_of_run
);

  localparam int CNT_W = $clog2(MAG_W);
  localparam int DIV_W = SAMPLE_W;

  back_state_t state, state_next;

  logic [1:0]              op;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        quot;
  logic [DIV_W:0]          rem;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;
  logic signed [ROW_W-1:0] y0, y1, link_row;

  logic                    need, done, out_free;
  logic signed [NUM_W-1:0] num;
  logic [DIV_W-1:0]        abs_num;
  logic signed [NUM_W-1:0] range;
  logic [DIV_W-1:0]        divisor;
  logic [DIV_W:0]          trial;
  logic                    qbit;
  logic signed [ROW_W-1:0] sat_row;
  logic                    ld_out, do_mul, do_div, do_wb, do_start, do_skip;

  // operand selection and divisor
  always_comb begin
    case (op)
      2'd0:    need = (job.y0sel == Y_SCALE);
      2'd1:    need = (job.y1sel == Y_SCALE);
      2'd2:    need = job.do_link;
      default: need = 1'b0;
    endcase
    case (op)
      2'd0:    num = job.num0;
      2'd1:    num = job.num1;
      default: num = job.num2;
    endcase
    abs_num  = num[NUM_W-1] ? DIV_W'(-num) : DIV_W'(num);
    range    = diff33(cfg.value_max, cfg.value_min);
    divisor  = (range > 0) ? range[DIV_W-1:0] : DIV_W'(1);
    done     = (op == 2'd3);
    out_free = !m_tvalid || m_tready;
    trial    = {rem[DIV_W-1:0], mag[MAG_W-1]};
    qbit     = (trial >= {1'b0, divisor});
    if (!neg) begin
      sat_row = (quot > MAG_W'(65535)) ? ROW_W'(65535) : ROW_W'(quot);
    end else begin
      sat_row = (quot > MAG_W'(65536)) ? -ROW_W'(65536) : -ROW_W'(quot);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (job_valid) state_next = BK_SEL;
      BK_SEL: begin
        if (done) begin
          if (out_free) state_next = BK_IDLE;
        end else if (need) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL:  state_next = BK_DIV;
      BK_DIV:  if (cnt == CNT_W'(MAG_W - 1)) state_next = BK_WB;
      BK_WB:   state_next = BK_SEL;
      default: state_next = BK_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    do_start = (state == BK_IDLE) && job_valid;
    do_skip  = (state == BK_SEL) && !done && !need;
    ld_out   = (state == BK_SEL) && done && out_free;
    do_mul   = (state == BK_MUL);
    do_div   = (state == BK_DIV);
    do_wb    = (state == BK_WB);
    job_pop  = ld_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld_out)        m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (do_start) op <= 2'd0;
    if (do_skip || do_wb) op <= op + 2'd1;
    if (do_mul) begin
      mag  <= MAG_W'(abs_num) * MAG_W'(cfg.pixel_height);
      neg  <= num[NUM_W-1];
      rem  <= '0;
      quot <= '0;
      cnt  <= '0;
    end
    if (do_div) begin
      rem  <= qbit ? trial - {1'b0, divisor} : trial;
      quot <= {quot[MAG_W-2:0], qbit};
      mag  <= {mag[MAG_W-2:0], 1'b0};
      cnt  <= cnt + CNT_W'(1);
    end
    if (do_wb) begin
      case (op)
        2'd0:    y0 <= sat_row;
        2'd1:    y1 <= sat_row;
        default: link_row <= sat_row;
      endcase
    end
    if (ld_out) begin
      segment_kind <= job.kind;
      column_x     <= job.x0;
      x_end        <= job.x1;
      last_of_run  <= job.last_of_run;
      case (job.y0sel)
        Y_SCALE: y_start <= y0;
        Y_LINK:  y_start <= link_row;
        default: y_start <= job.y0c;
      endcase
      case (job.y1sel)
        Y_SCALE: y_end <= y1;
        Y_COPY:  y_end <= y0;
        Y_LINK:  y_end <= link_row;
        default: y_end <= job.y1c;
      endcase
    end
  end

endmodule

>>> design/minmax_decimating_plotter_core.sv
// Top level of the min/max decimating plotter: configuration registers,
// front end, job queue and back end. Depends on mmdp_pkg and all mmdp_* modules.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata sample, tlast last_sample
//  m_*      out        m_tvalid/m_tready  tdata x/y, tuser kind, tlast last_of_run
//  cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// For each result, the back end scales every row that needs scaling (up to
// three per result) with its bit-serial divider, in the states BK_MUL, BK_DIV
// and BK_WB; constant rows skip these states. A job leaves the queue when its result is loaded.
// Synchronous active-high reset clears all control state and config to defaults.
// The front end keeps accepting samples while the queue has room; a stalled
// result register holds the back end only.
module minmax_decimating_plotter_core import mmdp_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic                s_tlast,   // last_sample
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [71:0]         m_tdata,   // column_x, x_end, y_start, y_end, zero pad
  output logic [1:0]          m_tuser,   // segment_kind
  output logic                m_tlast,   // last_of_run
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                    fj_valid, fj_ready, bj_valid, bj_pop;
  job_t                    fj, bj;
  logic [COL_W-1:0]        column_x, x_end;
  logic signed [ROW_W-1:0] y_start, y_end;

  assign cfg_ready = 1'b1;

  // configuration transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plot_mode          <= '0;
      cfg.value_min          <= '0;
      cfg.value_max          <= SAMPLE_W'(1);
      cfg.pixel_height       <= HEIGHT_W'(100);
      cfg.samples_per_column <= SPC_W'(1);
      cfg.plot_zero          <= 1'b1;
      cfg.invert_bars        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   cfg.plot_mode          <= cfg_data[1:0];
        REG_VMIN:   cfg.value_min          <= cfg_data;
        REG_VMAX:   cfg.value_max          <= cfg_data;
        REG_HEIGHT: cfg.pixel_height       <= cfg_data[HEIGHT_W-1:0];
        REG_SPC:    cfg.samples_per_column <= cfg_data[SPC_W-1:0];
        REG_PZERO:  cfg.plot_zero          <= cfg_data[0];
        REG_INVERT: cfg.invert_bars        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mmdp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .sample      (s_tdata),
    .last_sample (s_tlast),
    .job_valid   (fj_valid),
    .job         (fj),
    .job_ready   (fj_ready)
  );

  mmdp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj),
    .rd_valid (bj_valid),
    .rd_pop   (bj_pop),
    .rd_data  (bj)
  );

  mmdp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (bj_valid),
    .job          (bj),
    .job_pop      (bj_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .segment_kind (m_tuser),
    .column_x     (column_x),
    .x_end        (x_end),
    .y_start      (y_start),
    .y_end        (y_end),
    .last_of_run  (m_tlast)
  );

  assign m_tdata = {6'd0, y_end, y_start, x_end, column_x};

  // checks
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid && !bj_valid)
    else $error("output or queue not empty after reset");
  a_link_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_LINK |-> x_end == column_x + COL_W'(1))
    else $error("connector does not span to the next column");
  a_col_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_LINK |-> x_end == column_x)
    else $error("column segment spans more than one column");

endmodule
